// File: rtl/magnetometer_heading_top_assert.svh
// ----------------------------------------------------------------------------
// Magnetometer heading assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_HEADING_TOP_ASSERT_SVH
`define MAGNETOMETER_HEADING_TOP_ASSERT_SVH

// same-cycle implication
`define MHD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mhd_pkg.sv
// ----------------------------------------------------------------------------
// Magnetometer heading package
// Widths, CORDIC angle table and the shared CORDIC iteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhd_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int SAMPLE_BITS     = 16;
    localparam int GUARD_BITS      = 24;
    localparam int ATAN_ENTRIES    = 24;
    localparam int STAGES          = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS
                                                                   : ATAN_ENTRIES;
    localparam int IN_W            = 16;
    localparam int PRE_W           = SAMPLE_BITS + 2;
    localparam int VEC_W           = PRE_W + GUARD_BITS + 2;
    localparam int ANG_W           = 32;
    localparam int HEAD_W          = 15;
    localparam int PROD_W          = ANG_W + HEAD_W;
    localparam int FULL_TURN_UNITS = 23040;

    localparam logic [ANG_W-1:0] HALF_TURN = {1'b1, {(ANG_W-1){1'b0}}};

    typedef logic signed [VEC_W-1:0] vec_t;

    typedef struct packed {
        vec_t             x;
        vec_t             y;
        logic [ANG_W-1:0] acc;
        logic             zero;
    } cordic_t;

    // atan(2^-i), full turn = 2^32
    function automatic logic [ANG_W-1:0] atan_angle(input int idx);
        logic [ANG_W-1:0] a;
        case (idx)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

    // one vectoring iteration, shifts floor toward minus infinity
    function automatic cordic_t cordic_step(input cordic_t s, input int idx);
        vec_t    xs;
        vec_t    ys;
        cordic_t r;
        xs = $signed(s.x) >>> idx;
        ys = $signed(s.y) >>> idx;
        r  = s;
        if (!s.y[VEC_W-1])
        begin
            r.x   = s.x + ys;
            r.y   = s.y - xs;
            r.acc = s.acc + atan_angle(idx);
        end
        else
        begin
            r.x   = s.x - ys;
            r.y   = s.y + xs;
            r.acc = s.acc - atan_angle(idx);
        end
        return r;
    endfunction

endpackage

// File: rtl/magnetometer_heading_top.sv
// ----------------------------------------------------------------------------
// Magnetometer heading top level
// Compass heading from one X/Y magnetometer sample via a pipelined CORDIC.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    mag_x, mag_y
//  output    out        out_valid / out_stall  heading
//  config    in         cfg_we                 cfg_wdata (flip_y_axis)
//
//  One sample per cycle sustained while out_stall is low; the registers in order are:
//  input register, one CORDIC iteration per stage, multiply, round/output.
//  Reset clears all stage valid bits and sets flip_y_axis to 1.
//  A stall holds each full stage; empty stages ahead of it keep filling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "magnetometer_heading_top_assert.svh"

module magnetometer_heading_top
    import mhd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [IN_W-1:0]   mag_x,
    input  logic [IN_W-1:0]   mag_y,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [HEAD_W-1:0] heading,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);

    logic            flip_reg;
    logic            in_valid_reg;
    logic [IN_W-1:0] mag_x_reg;
    logic [IN_W-1:0] mag_y_reg;
    logic            in_ready;
    cordic_t         prep_vec;
    logic            cordic_ready;
    logic            cordic_valid;
    cordic_t         cordic_data;
    logic            head_ready;

    assign in_ready = !in_valid_reg || cordic_ready;
    assign in_stall = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg     <= 1'b1;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                flip_reg <= cfg_wdata;
            if (in_ready)
                in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mag_x_reg <= mag_x;
            mag_y_reg <= mag_y;
        end
    end

    mhd_prep u_prep (
        .mag_x (mag_x_reg),
        .mag_y (mag_y_reg),
        .flip  (flip_reg),
        .vec   (prep_vec)
    );

    mhd_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid_reg),
        .up_data  (prep_vec),
        .up_ready (cordic_ready),
        .dn_valid (cordic_valid),
        .dn_data  (cordic_data),
        .dn_ready (head_ready)
    );

    mhd_heading u_heading (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (cordic_valid),
        .up_data   (cordic_data),
        .up_ready  (head_ready),
        .out_valid (out_valid),
        .heading   (heading),
        .out_stall (out_stall)
    );

    `MHD_ASSERT_SAME(a_heading_range, out_valid, heading < HEAD_W'(FULL_TURN_UNITS), "heading out of range")
    `MHD_ASSERT_SAME(a_stall_needs_item, in_stall, in_valid_reg, "input stalled with empty input stage")
    `MHD_ASSERT_NEXT(a_input_hold, in_valid_reg && in_stall, $stable(mag_x_reg) && $stable(mag_y_reg), "held sample changed")

endmodule

// File: rtl/mhd_prep.sv
// ----------------------------------------------------------------------------
// Magnetometer heading sample preparation
// Sign extension, Y flip, zero detect, left half plane fold and scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhd_prep
    import mhd_pkg::*;
(
    input  logic [IN_W-1:0] mag_x,
    input  logic [IN_W-1:0] mag_y,
    input  logic            flip,
    output cordic_t         vec
);

    logic signed [PRE_W-1:0] xs;
    logic signed [PRE_W-1:0] ys;
    logic signed [PRE_W-1:0] yf;
    logic signed [PRE_W-1:0] xh;
    logic signed [PRE_W-1:0] yh;

    always_comb
    begin
        xs = PRE_W'($signed(mag_x[SAMPLE_BITS-1:0]));
        ys = PRE_W'($signed(mag_y[SAMPLE_BITS-1:0]));
        yf = flip ? -ys : ys;
        xh = xs[PRE_W-1] ? -xs : xs;
        yh = xs[PRE_W-1] ? -yf : yf;

        vec.zero = (xs == '0) && (yf == '0);
        vec.acc  = xs[PRE_W-1] ? HALF_TURN : '0;
        vec.x    = VEC_W'(xh) <<< GUARD_BITS;
        vec.y    = VEC_W'(yh) <<< GUARD_BITS;
    end

endmodule

// File: rtl/mhd_cordic.sv
// ----------------------------------------------------------------------------
// Magnetometer heading CORDIC pipeline
// One registered vectoring iteration per stage, per-stage valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhd_cordic
    import mhd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    input  cordic_t up_data,
    output logic    up_ready,
    output logic    dn_valid,
    output cordic_t dn_data,
    input  logic    dn_ready
);

    logic    valid_reg [0:STAGES-1];
    cordic_t data_reg  [0:STAGES-1];
    cordic_t data_next [0:STAGES-1];
    logic    valid_in  [0:STAGES-1];
    cordic_t data_in   [0:STAGES-1];
    logic    ready     [0:STAGES];

    assign ready[STAGES] = dn_ready;
    assign up_ready      = ready[0];
    assign dn_valid      = valid_reg[STAGES-1];
    assign dn_data       = data_reg[STAGES-1];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        if (g == 0)
        begin : g_first
            assign valid_in[g] = up_valid;
            assign data_in[g]  = up_data;
        end
        else
        begin : g_rest
            assign valid_in[g] = valid_reg[g-1];
            assign data_in[g]  = data_reg[g-1];
        end

        assign ready[g]     = !valid_reg[g] || ready[g+1];
        assign data_next[g] = cordic_step(data_in[g], g);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (ready[g])
                valid_reg[g] <= valid_in[g];
        end

        always_ff @(posedge clk)
        begin
            if (ready[g] && valid_in[g])
                data_reg[g] <= data_next[g];
        end
    end

endmodule

// File: rtl/mhd_heading.sv
// ----------------------------------------------------------------------------
// Magnetometer heading output scaling
// Binary angle times full turn, round half up, wrap and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhd_heading
    import mhd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  cordic_t           up_data,
    output logic              up_ready,
    output logic              out_valid,
    output logic [HEAD_W-1:0] heading,
    input  logic              out_stall
);

    logic              mvalid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              zero_reg;
    logic              out_valid_reg;
    logic [HEAD_W-1:0] heading_reg;
    logic [HEAD_W-1:0] heading_next;
    logic              ready_b;
    logic [PROD_W:0]   round_sum;
    logic [HEAD_W:0]   rounded;

    assign ready_b   = !out_valid_reg || !out_stall;
    assign up_ready  = !mvalid_reg || ready_b;
    assign prod_next = PROD_W'(up_data.acc) * PROD_W'(FULL_TURN_UNITS);

    always_comb
    begin
        round_sum = {1'b0, prod_reg} + (PROD_W+1)'(HALF_TURN);
        rounded   = round_sum[PROD_W:ANG_W];
        if (zero_reg || (rounded >= (HEAD_W+1)'(FULL_TURN_UNITS)))
            heading_next = '0;
        else
            heading_next = rounded[HEAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
                mvalid_reg <= up_valid;
            if (ready_b)
                out_valid_reg <= mvalid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            prod_reg <= prod_next;
            zero_reg <= up_data.zero;
        end
        if (ready_b && mvalid_reg)
            heading_reg <= heading_next;
    end

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;

endmodule
